// ===== hw/rtl/ccbr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccbr_pkg
// Shared constants, types and helpers for the ChaCha20 bounded random block.
// ----------------------------------------------------------------------------
package ccbr_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int DR_W          = $clog2(DOUBLE_ROUNDS);
    localparam int NUM_KEYS      = 4;
    localparam int KEY_IDX_W     = 2;
    localparam int CFG_IDX_W     = 4;

    localparam logic [31:0] SIGMA [4] = '{
        32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
    };

    typedef logic [NUM_KEYS-1:0][63:0] ccbr_key_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ccbr_stat_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

// ===== hw/rtl/ccbr_if.sv =====
// ----------------------------------------------------------------------------
// ccbr_if
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface ccbr_req_if;
    logic        valid;
    logic        ready;
    logic        restart;
    logic [63:0] upper;

    modport source (output valid, restart, upper, input ready);
    modport sink   (input valid, restart, upper, output ready);
endinterface

interface ccbr_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

interface ccbr_cfg_if import ccbr_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/chacha20_bounded_random.sv =====
// ----------------------------------------------------------------------------
// chacha20_bounded_random
// Keyed ChaCha20 stream (zero nonce, 64-bit block counter) giving unbiased
// values below a requested bound by multiply-and-reject.
// ----------------------------------------------------------------------------
// One request at a time: ready is low from acceptance until the response is
// taken. A draw costs two word fetches, the multiply (four partial products)
// and a compare. Every 8 draws a new block is made by the shared half
// quarter-round unit, each quarter round in two halves. The first time in a
// request that a draw's low half falls below the bound, the threshold is
// computed by a 64-step serial divider. A bound of zero answers zero without
// a draw.
// Key writes are held off while a block is being made; they take effect at
// the next block.
module chacha20_bounded_random import ccbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ccbr_req_if.sink   req,
    ccbr_rsp_if.source rsp,
    ccbr_cfg_if.sink   cfg
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_WORD = 7'b0000010,
        S_GEN  = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_MOD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } top_state_t;

    top_state_t  state_reg, state_next;
    ccbr_key_t   key_reg;
    logic [63:0] ctr_reg, ctr_next;
    logic [4:0]  widx_reg, widx_next;
    logic        hisel_reg, hisel_next;
    logic        thr_ok_reg, thr_ok_next;
    logic [63:0] upper_reg, upper_next;
    logic [63:0] draw_reg, draw_next;
    logic [63:0] thr_reg, thr_next;
    logic [63:0] value_reg, value_next;

    logic         core_start, mul_start, mod_start;
    logic [31:0]  ks_word;
    logic [127:0] prod;
    logic [63:0]  rem;
    ccbr_stat_t   core_stat, mul_stat, mod_stat;

    ccbr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (core_start),
        .key     (key_reg),
        .counter (ctr_reg),
        .rd_idx  (widx_reg[3:0]),
        .rd_word (ks_word),
        .stat    (core_stat)
    );

    ccbr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (draw_reg),
        .b     (upper_reg),
        .prod  (prod),
        .stat  (mul_stat)
    );

    ccbr_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .upper (upper_reg),
        .rem   (rem),
        .stat  (mod_stat)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.value = value_reg;
    assign cfg.ready = (state_reg != S_GEN) && !core_start;

    always_comb
    begin
        state_next  = state_reg;
        ctr_next    = ctr_reg;
        widx_next   = widx_reg;
        hisel_next  = hisel_reg;
        thr_ok_next = thr_ok_reg;
        upper_next  = upper_reg;
        draw_next   = draw_reg;
        thr_next    = thr_reg;
        value_next  = value_reg;
        core_start  = 1'b0;
        mul_start   = 1'b0;
        mod_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    upper_next  = req.upper;
                    thr_ok_next = 1'b0;
                    hisel_next  = 1'b0;
                    if (req.restart)
                    begin
                        ctr_next  = '0;
                        widx_next = 5'd16;
                    end
                    if (req.upper == 64'd0)
                    begin
                        value_next = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_WORD;
                    end
                end
            end
            S_WORD:
            begin
                if (widx_reg[4])
                begin
                    core_start = 1'b1;
                    state_next = S_GEN;
                end
                else
                begin
                    widx_next = widx_reg + 5'd1;
                    if (!hisel_reg)
                    begin
                        draw_next[31:0] = ks_word;
                        hisel_next      = 1'b1;
                    end
                    else
                    begin
                        draw_next[63:32] = ks_word;
                        hisel_next       = 1'b0;
                        mul_start        = 1'b1;
                        state_next       = S_MUL;
                    end
                end
            end
            S_GEN:
            begin
                if (core_stat.done)
                begin
                    ctr_next   = ctr_reg + 64'd1;
                    widx_next  = '0;
                    state_next = S_WORD;
                end
            end
            S_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (prod[63:0] >= upper_reg)
                begin
                    value_next = prod[127:64];
                    state_next = S_OUT;
                end
                else if (!thr_ok_reg)
                begin
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
                else if (prod[63:0] < thr_reg)
                begin
                    state_next = S_WORD;
                end
                else
                begin
                    value_next = prod[127:64];
                    state_next = S_OUT;
                end
            end
            S_MOD:
            begin
                if (mod_stat.done)
                begin
                    thr_next    = rem;
                    thr_ok_next = 1'b1;
                    state_next  = S_CHK;
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            key_reg    <= '0;
            ctr_reg    <= '0;
            widx_reg   <= 5'd16;
            hisel_reg  <= 1'b0;
            thr_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ctr_reg    <= ctr_next;
            widx_reg   <= widx_next;
            hisel_reg  <= hisel_next;
            thr_ok_reg <= thr_ok_next;
            if (cfg.valid && cfg.ready && (cfg.index < CFG_IDX_W'(NUM_KEYS)))
            begin
                key_reg[cfg.index[KEY_IDX_W-1:0]] <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg <= upper_next;
        draw_reg  <= draw_next;
        thr_reg   <= thr_next;
        value_reg <= value_next;
    end

endmodule

// ===== hw/rtl/ccbr_core.sv =====
// ----------------------------------------------------------------------------
// ccbr_core
// ChaCha20 block function on one shared half quarter-round unit. The unit
// always works on column 0; rows are rotated after each quarter round so the
// next column (or diagonal) lands there. Result words stay in the state regs.
// ----------------------------------------------------------------------------
module ccbr_core import ccbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  ccbr_key_t   key,
    input  logic [63:0] counter,
    input  logic [3:0]  rd_idx,
    output logic [31:0] rd_word,
    output ccbr_stat_t  stat
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_FIN  = 3'b100
    } core_state_t;

    core_state_t      state_reg, state_next;
    logic [31:0]      st_reg [16];
    logic [31:0]      st_next [16];
    logic [31:0]      init_w [16];
    logic [31:0]      t_w [16];
    logic             phase_reg, phase_next;
    logic [2:0]       qr_reg, qr_next;
    logic [DR_W-1:0]  dr_reg, dr_next;
    logic [31:0]      a1, b1, c1, d1;
    logic [31:0]      na, nb, nc, nd;
    logic [1:0]       rot [4];
    logic [127:0]     row_w [4];
    logic [255:0]     row_sh [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_w[i]         = SIGMA[i];
            init_w[4 + 2 * i] = key[i][31:0];
            init_w[5 + 2 * i] = key[i][63:32];
        end
        init_w[12] = counter[31:0];
        init_w[13] = counter[63:32];
        init_w[14] = '0;
        init_w[15] = '0;
    end

    // half quarter round: 16/12 on phase 0, 8/7 on phase 1
    always_comb
    begin
        a1 = st_reg[0] + st_reg[4];
        d1 = phase_reg ? rotl32(st_reg[12] ^ a1, 8) : rotl32(st_reg[12] ^ a1, 16);
        c1 = st_reg[8] + d1;
        b1 = phase_reg ? rotl32(st_reg[4] ^ c1, 7) : rotl32(st_reg[4] ^ c1, 12);
        na = a1;
        nb = b1;
        nc = c1;
        nd = d1;
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            t_w[i] = st_reg[i];
        end
        t_w[0]  = na;
        t_w[4]  = nb;
        t_w[8]  = nc;
        t_w[12] = nd;

        // extra row offsets diagonalise after the 4th and restore after the 8th
        for (int r = 0; r < 4; r++)
        begin
            if (qr_reg == 3'd3)
            begin
                rot[r] = 2'(1 + r);
            end
            else if (qr_reg == 3'd7)
            begin
                rot[r] = 2'(1 - r);
            end
            else
            begin
                rot[r] = 2'd1;
            end
            row_w[r]  = {t_w[4*r+3], t_w[4*r+2], t_w[4*r+1], t_w[4*r]};
            row_sh[r] = {row_w[r], row_w[r]} >> {rot[r], 5'd0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        qr_next    = qr_reg;
        dr_next    = dr_reg;
        st_next    = st_reg;

        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    st_next    = init_w;
                    phase_next = 1'b0;
                    qr_next    = '0;
                    dr_next    = '0;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                phase_next = ~phase_reg;
                if (!phase_reg)
                begin
                    st_next = t_w;
                end
                else
                begin
                    for (int r = 0; r < 4; r++)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            st_next[4*r+j] = row_sh[r][32*j +: 32];
                        end
                    end
                    qr_next = qr_reg + 3'd1;
                    if (qr_reg == 3'd7)
                    begin
                        dr_next = dr_reg + DR_W'(1);
                        if (dr_reg == DR_W'(DOUBLE_ROUNDS - 1))
                        begin
                            state_next = C_FIN;
                        end
                    end
                end
            end
            C_FIN:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    st_next[i] = st_reg[i] + init_w[i];
                end
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            phase_reg <= 1'b0;
            qr_reg    <= '0;
            dr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            qr_reg    <= qr_next;
            dr_reg    <= dr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign rd_word   = st_reg[rd_idx];
    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_FIN);

endmodule

// ===== hw/rtl/ccbr_mul.sv =====
// ----------------------------------------------------------------------------
// ccbr_mul
// 64 x 64 -> 128 multiply on one 32 x 32 multiplier, four partial products
// accumulated over successive cycles. Operands must hold while busy.
// ----------------------------------------------------------------------------
module ccbr_mul import ccbr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod,
    output ccbr_stat_t   stat
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_DONE = 3'b100
    } mul_state_t;

    mul_state_t   state_reg, state_next;
    logic [2:0]   step_reg, step_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sh_reg, sh_next;
    logic [127:0] acc_reg, acc_next;
    logic [31:0]  opa, opb;

    always_comb
    begin
        opa     = step_reg[1] ? a[63:32] : a[31:0];
        opb     = step_reg[0] ? b[63:32] : b[31:0];
        pp_next = pp_reg;
        sh_next = sh_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        state_next = state_reg;

        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                if (!step_reg[2])
                begin
                    pp_next = 64'(opa) * 64'(opb);
                    sh_next = 2'({1'b0, step_reg[1]} + {1'b0, step_reg[0]});
                end
                if (step_reg != 3'd0)
                begin
                    acc_next = acc_reg + (128'(pp_reg) << {sh_reg, 5'd0});
                end
                step_next = step_reg + 3'd1;
                if (step_reg[2])
                begin
                    state_next = M_DONE;
                end
            end
            M_DONE:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    assign prod      = acc_reg;
    assign stat.busy = (state_reg != M_IDLE);
    assign stat.done = (state_reg == M_DONE);

endmodule

// ===== hw/rtl/ccbr_mod.sv =====
// ----------------------------------------------------------------------------
// ccbr_mod
// Rejection threshold (2^64 - upper) mod upper, restoring division, one
// quotient bit per cycle. upper must be non-zero and hold while busy.
// ----------------------------------------------------------------------------
module ccbr_mod import ccbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] upper,
    output logic [63:0] rem,
    output ccbr_stat_t  stat
);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } mod_state_t;

    mod_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [64:0] rem_reg, rem_next;
    logic [64:0] rem_sh;

    always_comb
    begin
        rem_sh     = {rem_reg[63:0], num_reg[63]};
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;

        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    num_next   = 64'd0 - upper;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                num_next = {num_reg[62:0], 1'b0};
                if (rem_sh >= {1'b0, upper})
                begin
                    rem_next = rem_sh - {1'b0, upper};
                end
                else
                begin
                    rem_next = rem_sh;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign rem       = rem_reg[63:0];
    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = (state_reg == D_DONE);

endmodule

// ===== hw/rtl/ccbr_chk.sv =====
// ----------------------------------------------------------------------------
// ccbr_chk
// Port-level checks for the bounded random block, bound to the top level.
// ----------------------------------------------------------------------------
module ccbr_chk import ccbr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [63:0] upper,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] value
);

    logic [63:0] upper_q_reg;

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            upper_q_reg <= upper;
        end
    end

    a_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (upper_q_reg != 64'd0) |-> value < upper_q_reg)
        else $error("response not below bound");

    a_zero_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (upper_q_reg == 64'd0) |-> value == 64'd0)
        else $error("zero bound gave non-zero response");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request taken while response pending");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready held after request");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(value))
        else $error("stalled response changed");

endmodule

bind chacha20_bounded_random ccbr_chk u_ccbr_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .upper     (req.upper),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .value     (rsp.value)
);
